>>> rtl/core/tdl_pkg.sv
// Package for the tridiagonal LDL^H factorization block.
// Holds the input and result word structs and the status codes; no dependencies.
package tdl_pkg;

  localparam int DW = 32;
  localparam int RW = 16;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  typedef struct packed {
    logic signed [DW-1:0] diag_in;
    logic signed [DW-1:0] sub_re;
    logic signed [DW-1:0] sub_im;
    logic                 last;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0] diag_out;
    logic signed [DW-1:0] mult_re;
    logic signed [DW-1:0] mult_im;
    logic [RW-1:0]        row;
    logic [1:0]           status;
    logic                 last_out;
  } out_word_t;

endpackage

>>> rtl/core/tridiagonal_ldlh_factor.sv
// Top level of the streaming tridiagonal LDL^H factorization.
// Depends on tdl_pkg for the word structs and status codes.
//
//   channel | ports                          | direction
//   input   | in_valid, in_stall, in_word    | in, one matrix row per word
//   result  | out_valid, out_stall, out_word | out, one result word per row
//
// A row that divides passes from acceptance through the divide, multiply and done states
// to a valid result word: the real and imaginary quotients come from one restoring
// divider that yields one quotient bit per cycle, and each correction product is built
// by a shift-and-add multiplier that consumes one multiplier bit per cycle.
// Rows that fail, are skipped, or are last go from acceptance straight to the done state.
// Reset (rst_n low, synchronous) clears the correction, row counter and failure flag.
// A stalled result word holds in the output register; the next input word is taken
// only once the result register is free.

module tridiagonal_ldlh_factor #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_ORDER  = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdl_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tdl_pkg::out_word_t out_word
);
  import tdl_pkg::*;

  // The word width is fixed by the package structs.
  localparam int DATA_WIDTH = DW;

  // Quotient before saturation needs DATA_WIDTH+FRAC_BITS bits of magnitude.
  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  // Product of two DATA_WIDTH values.
  localparam int PW = 2 * DATA_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic signed [DATA_WIDTH-1:0] corr_r, corr_nxt;
  logic [RW-1:0]                rowc_r, rowc_nxt;
  logic                         failed_r, failed_nxt;

  // Row context.
  logic signed [DATA_WIDTH-1:0] d_r, d_nxt;
  logic signed [DATA_WIDTH-1:0] er_r, er_nxt, ei_r, ei_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [1:0]                   st_r, st_nxt;
  logic                         last_r, last_nxt;
  logic                         part_r, part_nxt;  // 0 real, 1 imaginary

  // Divider: remainder, quotient shift register, bit counter.
  logic [DATA_WIDTH:0]   rem_r, rem_nxt;
  logic [NW-1:0]         num_r, num_nxt;
  logic [NW-1:0]         quo_r, quo_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;

  logic signed [DATA_WIDTH-1:0] fr_r, fr_nxt, fi_r, fi_nxt;

  // Serial multiplier: accumulator, shifted multiplicand, multiplier bits.
  logic signed [PW-1:0]   acc_r, acc_nxt;
  logic signed [PW-1:0]   mcand_r, mcand_nxt;
  logic [DATA_WIDTH-1:0]  mplier_r, mplier_nxt;
  logic signed [PW+1:0]   csum_r, csum_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  // Combinational helpers.
  logic signed [DATA_WIDTH:0]   dsub;
  logic signed [DATA_WIDTH-1:0] dsat;
  logic [DATA_WIDTH:0]          rem_sh, rem_try;
  logic [NW:0]                  qmag;
  logic signed [DATA_WIDTH-1:0] qsat;
  logic signed [PW-1:0]         pfl;
  logic signed [PW+1:0]         csum_fin;
  logic signed [DATA_WIDTH-1:0] csat;
  logic [RW:0]                  row_inc;

  assign dsub = {in_word.diag_in[DATA_WIDTH-1], in_word.diag_in}
              - {corr_r[DATA_WIDTH-1], corr_r};
  assign dsat = (dsub > $signed({1'b0, DMAX})) ? DMAX :
                (dsub < $signed({1'b1, DMIN})) ? DMIN : dsub[DATA_WIDTH-1:0];

  assign rem_sh  = {rem_r[DATA_WIDTH-1:0], num_r[NW-1]};
  assign rem_try = rem_sh - {1'b0, d_r};

  // Quotient magnitude after the final bit, with sign and saturation.
  always_comb begin
    qmag = {1'b0, quo_r};
    if (neg_r) begin
      qsat = (qmag > {1'b0, {(NW-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}})
             ? DMIN : DATA_WIDTH'(-$signed(qmag));
    end else begin
      qsat = (qmag > {{(NW-DATA_WIDTH+1){1'b0}}, DMAX}) ? DMAX : DATA_WIDTH'(qmag);
    end
  end

  // Floor shift of the finished product, summed into the correction.
  assign pfl      = acc_r >>> FRAC_BITS;
  assign csum_fin = csum_r + {{2{pfl[PW-1]}}, pfl};
  assign csat = (csum_fin > $signed({{(PW+2-DATA_WIDTH){1'b0}}, DMAX})) ? DMAX :
                (csum_fin < $signed({{(PW+2-DATA_WIDTH){1'b1}}, DMIN})) ? DMIN :
                csum_fin[DATA_WIDTH-1:0];

  assign row_inc = {1'b0, rowc_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    corr_nxt = corr_r; rowc_nxt = rowc_r; failed_nxt = failed_r;
    d_nxt = d_r; er_nxt = er_r; ei_nxt = ei_r; row_nxt = row_r;
    st_nxt = st_r; last_nxt = last_r; part_nxt = part_r;
    rem_nxt = rem_r; num_nxt = num_r; quo_nxt = quo_r; cnt_nxt = cnt_r; neg_nxt = neg_r;
    fr_nxt = fr_r; fi_nxt = fi_r;
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r; csum_nxt = csum_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          er_nxt = in_word.sub_re; ei_nxt = in_word.sub_im;
          row_nxt = rowc_r; last_nxt = in_word.last;
          fr_nxt = '0; fi_nxt = '0;
          if (failed_r) begin
            d_nxt = in_word.diag_in; st_nxt = ST_SKIP; state_nxt = S_DONE;
          end else if (dsat <= 0) begin
            d_nxt = dsat; st_nxt = ST_FAIL; failed_nxt = 1'b1; state_nxt = S_DONE;
          end else begin
            d_nxt = dsat; st_nxt = ST_OK;
            state_nxt = in_word.last ? S_DONE : S_DIV;
            part_nxt = 1'b0;
            rem_nxt = '0; quo_nxt = '0; cnt_nxt = '0;
            num_nxt = {(in_word.sub_re[DATA_WIDTH-1] ? DATA_WIDTH'(-in_word.sub_re)
                                                     : in_word.sub_re),
                       {FRAC_BITS{1'b0}}};
            neg_nxt = in_word.sub_re[DATA_WIDTH-1];
          end
        end
      end
      S_DIV: begin
        if (cnt_r == CW'(NW)) begin
          if (!part_r) begin
            fr_nxt = qsat; part_nxt = 1'b1;
            rem_nxt = '0; quo_nxt = '0; cnt_nxt = '0;
            neg_nxt = ei_r[DATA_WIDTH-1];
            // The imaginary quotient starts from the magnitude of ei.
            num_nxt = {(ei_r[DATA_WIDTH-1] ? DATA_WIDTH'(-ei_r) : ei_r),
                       {FRAC_BITS{1'b0}}};
          end else begin
            fi_nxt = qsat; part_nxt = 1'b0;
            acc_nxt = '0; csum_nxt = '0; cnt_nxt = '0;
            mcand_nxt = PW'(er_r);
            mplier_nxt = fr_r;
            state_nxt = S_MUL;
          end
        end else begin
          if (!rem_try[DATA_WIDTH]) begin
            rem_nxt = rem_try; quo_nxt = {quo_r[NW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;  quo_nxt = {quo_r[NW-2:0], 1'b0};
          end
          num_nxt = {num_r[NW-2:0], 1'b0};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        if (cnt_r == CW'(DATA_WIDTH)) begin
          if (!part_r) begin
            csum_nxt = csum_fin;
            part_nxt = 1'b1; acc_nxt = '0; cnt_nxt = '0;
            mcand_nxt = PW'(ei_r); mplier_nxt = fi_r;
          end else begin
            corr_nxt = csat;
            state_nxt = S_DONE;
          end
        end else begin
          // Two's complement multiplier: the top bit weighs negative.
          if (mplier_r[0]) begin
            if (cnt_r == CW'(DATA_WIDTH - 1)) acc_nxt = acc_r - mcand_r;
            else                              acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt = mcand_r <<< 1;
          mplier_nxt = {1'b0, mplier_r[DATA_WIDTH-1:1]};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        out_nxt.diag_out = d_r;
        out_nxt.mult_re  = fr_r;
        out_nxt.mult_im  = fi_r;
        out_nxt.row      = row_r;
        out_nxt.status   = st_r;
        out_nxt.last_out = last_r;
        out_valid_nxt = 1'b1;
        if (last_r) begin
          corr_nxt = '0; rowc_nxt = '0; failed_nxt = 1'b0;
        end else if ({{(32-RW-1){1'b0}}, row_inc} >= 32'(MAX_ORDER) || row_inc[RW]) begin
          rowc_nxt = '0;
        end else begin
          rowc_nxt = row_inc[RW-1:0];
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; corr_r <= '0; rowc_r <= '0; failed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; corr_r <= corr_nxt; rowc_r <= rowc_nxt;
      failed_r <= failed_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt; er_r <= er_nxt; ei_r <= ei_nxt; row_r <= row_nxt;
    st_r <= st_nxt; last_r <= last_nxt; part_r <= part_nxt;
    rem_r <= rem_nxt; num_r <= num_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    neg_r <= neg_nxt; fr_r <= fr_nxt; fi_r <= fi_nxt;
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt; csum_r <= csum_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // A word is taken only from the idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> state_r == S_IDLE)
    else $error("input taken while busy");

  // A failing row that is not last sets the failure flag for the following rows.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st_r == ST_FAIL && !last_r) |=> failed_r)
    else $error("failure flag lost");

  // Rows after a failure are reported as skipped, never as ok.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && failed_r && st_r == ST_OK) |-> 1'b0)
    else $error("ok row after failure");

  // The correction is only changed at the end of the multiply or at matrix end.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DIV) |=> $stable(corr_r))
    else $error("correction changed early");

endmodule

>>> sim/tdl_checker.sv
// Checker for the tridiagonal LDL^H factorization block: predicts each result word
// from the accepted input words and compares it field by field. Depends on tdl_pkg.
module tdl_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tdl_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tdl_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending,
  output int                 rows_seen,
  output int                 pivots_failed
);
  import tdl_pkg::*;

  localparam int FB = 16;
  localparam longint DMAX = 64'sd2147483647;
  localparam longint DMIN = -64'sd2147483648;

  longint    carry_corr;
  bit [15:0] next_row;
  bit        matrix_failed;
  out_word_t factor_q[$];

  function automatic longint clamp(longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  // Arithmetic shift right is a floor for negative values too.
  function automatic longint shr_floor(longint p);
    return p >>> FB;
  endfunction

  function automatic longint qdiv(longint x, longint d);
    longint num;
    num = x * 65536;
    return clamp(num / d);
  endfunction

  task automatic predict_row(in_word_t w);
    out_word_t r;
    longint dg, er, ei, d, fr, fi;
    dg = longint'(w.diag_in);
    er = longint'(w.sub_re);
    ei = longint'(w.sub_im);
    fr = 0;
    fi = 0;
    r = '0;
    if (matrix_failed) begin
      d = dg;
      r.status = ST_SKIP;
    end else begin
      d = clamp(dg - carry_corr);
      if (d <= 0) begin
        r.status = ST_FAIL;
        matrix_failed = 1'b1;
        pivots_failed++;
      end else begin
        r.status = ST_OK;
        if (!w.last) begin
          fr = qdiv(er, d);
          fi = qdiv(ei, d);
          carry_corr = clamp(shr_floor(fr * er) + shr_floor(fi * ei));
        end
      end
    end
    r.diag_out = d[31:0];
    r.mult_re  = fr[31:0];
    r.mult_im  = fi[31:0];
    r.row      = next_row;
    r.last_out = w.last;
    factor_q.push_back(r);
    if (w.last) begin
      carry_corr = 0;
      next_row = '0;
      matrix_failed = 1'b0;
    end else begin
      next_row = next_row + 16'd1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      carry_corr = 0;
      next_row = '0;
      matrix_failed = 1'b0;
      fail_count <= 0;
      rows_seen <= 0;
      pivots_failed = 0;
      pending <= 0;
      factor_q.delete();
    end else begin
      int        errs;
      out_word_t e;
      errs = 0;
      if (in_valid && !in_stall) begin
        predict_row(in_word);
        rows_seen <= rows_seen + 1;
      end
      if (out_valid && !out_stall) begin
        if (factor_q.size() == 0) begin
          $error("unexpected result word: row %0d", out_word.row);
          errs++;
        end else begin
          e = factor_q.pop_front();
          if (e.diag_out !== out_word.diag_out) begin
            $error("diag_out exp %h got %h", e.diag_out, out_word.diag_out);
            errs++;
          end
          if (e.mult_re !== out_word.mult_re) begin
            $error("mult_re exp %h got %h", e.mult_re, out_word.mult_re);
            errs++;
          end
          if (e.mult_im !== out_word.mult_im) begin
            $error("mult_im exp %h got %h", e.mult_im, out_word.mult_im);
            errs++;
          end
          if (e.row !== out_word.row) begin
            $error("row exp %0d got %0d", e.row, out_word.row);
            errs++;
          end
          if (e.status !== out_word.status) begin
            $error("status exp %0d got %0d", e.status, out_word.status);
            errs++;
          end
          if (e.last_out !== out_word.last_out) begin
            $error("last_out exp %0d got %0d", e.last_out, out_word.last_out);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= factor_q.size();
    end
  end
endmodule

>>> sim/tb_tridiagonal_ldlh_factor.sv
// Testbench top for tridiagonal_ldlh_factor: drives matrix rows, applies output
// back-pressure and reports the verdict. Depends on tdl_pkg and tdl_checker.
module tb_tridiagonal_ldlh_factor;
  import tdl_pkg::*;

  // Budget for one dividing row, with a margin.
  localparam int ROW_CYCLES = 180;
  localparam int LIMIT = 1200 * ROW_CYCLES * 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  int        fail_count, pending, rows_seen, pivots_failed;
  int        cycle = 0;
  // Receiver stall probability in percent, and a forced long hold-off.
  int        rx_idle_pct = 0;
  bit        rx_hold = 1'b0;

  always #5 clk = ~clk;

  tridiagonal_ldlh_factor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  tdl_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .fail_count(fail_count), .pending(pending),
    .rows_seen(rows_seen), .pivots_failed(pivots_failed)
  );

  // The cycle counter is the only timeout: a hung handshake ends up here.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("tb_tridiagonal_ldlh_factor: done, errors");
      $finish;
    end
  end

  // Receiver side: random stalls, or a long hold-off while rx_hold is set.
  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // Sends one word, optionally idling before it, and waits for acceptance.
  // Valid stays high from one word to the next when there is no idle gap.
  task automatic send_row(in_word_t w, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_word_t make_row(int sel, bit last);
    in_word_t w;
    w.last = last;
    case (sel)
      // Well-conditioned rows: diagonal clearly dominating the subdiagonal.
      0: begin
        w.diag_in = $signed($urandom_range(32'h0040_0000, 32'h0001_0000));
        w.sub_re  = $signed($urandom_range(32'h0001_0000)) - 32'sh0000_8000;
        w.sub_im  = $signed($urandom_range(32'h0001_0000)) - 32'sh0000_8000;
      end
      // Small pivots against large subdiagonals drive saturation.
      1: begin
        w.diag_in = $signed($urandom_range(32'h0000_0400, 1));
        w.sub_re  = $urandom;
        w.sub_im  = $urandom;
      end
      // Fully random bits, which often fail the pivot.
      default: begin
        w.diag_in = $urandom;
        w.sub_re  = $urandom;
        w.sub_im  = $urandom;
      end
    endcase
    return w;
  endfunction

  task automatic send_matrix(int idle_pct);
    int n, i, r;
    n = $urandom_range(8, 1);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      send_row(make_row(r < 75 ? 0 : (r < 88 ? 1 : 2), i == n - 1), idle_pct);
    end
  endtask

  // Drops valid and waits until the checker has seen every expected word.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t w;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, saturation, failing and skipped rows,
    // single-row matrices and the last flag ignoring the subdiagonal.
    w = '{diag_in: 32'sh0001_0000, sub_re: 32'sh0000_8000, sub_im: -32'sh0000_8000, last: 0};
    send_row(w, 0);
    w = '{diag_in: 32'sh0002_0000, sub_re: 32'sh7fff_ffff, sub_im: 32'sh8000_0000, last: 0};
    send_row(w, 0);
    w = '{diag_in: 32'sh7fff_ffff, sub_re: 32'sh7fff_ffff, sub_im: 32'sh7fff_ffff, last: 0};
    send_row(w, 0);
    w = '{diag_in: 32'sh0000_0001, sub_re: 32'sh8000_0000, sub_im: 32'sh7fff_ffff, last: 0};
    send_row(w, 0);
    w = '{diag_in: 32'sh8000_0000, sub_re: 32'sh0, sub_im: 32'sh0, last: 0};
    send_row(w, 0);  // skipped
    w = '{diag_in: 32'sh7fff_ffff, sub_re: 32'sh1234, sub_im: 32'sh0, last: 0};
    send_row(w, 0);  // skipped
    w = '{diag_in: 32'shffff_ffff, sub_re: 32'shffff_ffff, sub_im: 32'shffff_ffff, last: 1};
    send_row(w, 0);  // skipped last row
    w = '{diag_in: 32'sh0, sub_re: 32'sh1, sub_im: 32'sh1, last: 1};
    send_row(w, 0);  // zero pivot on a single-row matrix
    w = '{diag_in: 32'sh0003_0000, sub_re: 32'shffff_ffff, sub_im: 32'shffff_ffff, last: 1};
    send_row(w, 0);  // last row ignores the subdiagonal
    w = '{diag_in: 32'sh0001_0000, sub_re: 32'sh0001_0000, sub_im: 32'sh0, last: 0};
    send_row(w, 0);
    w = '{diag_in: 32'sh0001_0000, sub_re: 32'sh0, sub_im: 32'sh0, last: 1};
    send_row(w, 0);  // pivot exactly zero after the correction
    drain();

    // Random matrices in three idling phases.
    rx_idle_pct = 69;
    while (rows_seen < 300) send_matrix(7);
    rx_idle_pct = 7;
    while (rows_seen < 600) send_matrix(69);

    // Long receiver hold-off so the block fills and stalls its input.
    rx_hold = 1'b1;
    fork
      begin
        repeat (3 * ROW_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        for (k = 0; k < 4; k++) send_matrix(0);
        in_valid <= 1'b0;
      end
    join
    drain();

    rx_idle_pct = 0;
    while (rows_seen < 920) send_matrix(0);
    drain();
    repeat (ROW_CYCLES) @(posedge clk);

    $display("Factored %0d rows, %0d pivots not positive; stalls on both sides,",
             rows_seen, pivots_failed);
    $display("a long result hold-off and full drains were exercised.");
    if (fail_count == 0) begin
      $display("tb_tridiagonal_ldlh_factor: done, clean");
    end else begin
      $display("tb_tridiagonal_ldlh_factor: done, errors");
    end
    $finish;
  end
endmodule
